// ----- rtl/gpg_pkg.sv -----
// Package for the gradient pixel generator: widths, register indexes, payload types.
// Used by gpg_div and gradient_pixel_generator; no dependencies.
`default_nettype none
package gpg_pkg;

  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned MaxColors = 256;
  localparam int unsigned DimW      = 13;
  localparam int unsigned NcW       = 9;
  localparam int unsigned NumW      = 22;  // divider dividend / quotient width
  localparam int unsigned DenW      = 14;  // divider divisor width
  localparam int unsigned DivLat    = NumW;

  typedef enum logic [2:0] {
    REG_START  = 3'd0,
    REG_END    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_DIR    = 3'd4,
    REG_NCOL   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_VERT = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_HORZ = 2'd2,
    DIR_ANTI = 2'd3
  } dir_e;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic [7:0]  palette_index;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/gpg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on gpg_pkg for widths.
`default_nettype none
module gpg_div (
  input  wire logic                      clk_i,
  input  wire logic [gpg_pkg::NumW-1:0]  num_i,
  input  wire logic [gpg_pkg::DenW-1:0]  den_i,
  output logic      [gpg_pkg::NumW-1:0]  quo_o
);

  localparam int unsigned NW = gpg_pkg::NumW;
  localparam int unsigned DW = gpg_pkg::DenW;

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [DW-1:0] rem_d [NW];
  logic [NW-1:0] num_d [NW];
  logic [NW-1:0] quo_d [NW];
  logic [DW-1:0] den_d [NW];

  always_comb begin
    logic [DW-1:0] rem_s;
    logic [NW-1:0] num_s;
    logic [NW-1:0] quo_s;
    logic [DW-1:0] den_s;
    logic [DW:0]   trial;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        rem_s = '0;
        num_s = num_i;
        quo_s = '0;
        den_s = den_i;
      end else begin
        rem_s = rem_q[s-1];
        num_s = num_q[s-1];
        quo_s = quo_q[s-1];
        den_s = den_q[s-1];
      end
      trial = {rem_s, num_s[NW-1]};
      if (trial >= {1'b0, den_s}) begin
        rem_d[s] = DW'(trial - {1'b0, den_s});
        quo_d[s] = {quo_s[NW-2:0], 1'b1};
      end else begin
        rem_d[s] = trial[DW-1:0];
        quo_d[s] = {quo_s[NW-2:0], 1'b0};
      end
      num_d[s] = {num_s[NW-2:0], 1'b0};
      den_d[s] = den_s;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NW; s++) begin
      rem_q[s] <= rem_d[s];
      num_q[s] <= num_d[s];
      quo_q[s] <= quo_d[s];
      den_q[s] <= den_d[s];
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule
`default_nettype wire

// ----- rtl/gradient_pixel_generator.sv -----
// Gradient pixel generator top: config registers, index and color pipelines.
// Depends on gpg_pkg and gpg_div.
// Path: stage 0, y/x dividers, index stage, color stage 0 and dividers, output.
// One pixel per cycle: the index and color dividers are fully pipelined.
// busy is always low; results cannot be held off by the receiver.
// Reset restores register defaults and clears all valid bits.
`default_nettype none
module gradient_pixel_generator (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire gpg_pkg::pix_t pix_i,
  output logic               done_o,
  output gpg_pkg::res_t      res_o,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [23:0]   cfg_data_i
);

  localparam int unsigned NW  = gpg_pkg::NumW;
  localparam int unsigned DW  = gpg_pkg::DenW;
  localparam int unsigned LAT = gpg_pkg::DivLat;

  logic [23:0]                start_q, end_q;
  logic [gpg_pkg::DimW-1:0]   width_q, height_q;
  gpg_pkg::dir_e              dir_q;
  logic [gpg_pkg::NcW-1:0]    ncol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 24'h000000;
      end_q    <= 24'hFFFFFF;
      width_q  <= gpg_pkg::DimW'(256);
      height_q <= gpg_pkg::DimW'(256);
      dir_q    <= gpg_pkg::DIR_VERT;
      ncol_q   <= gpg_pkg::NcW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gpg_pkg::REG_START:  start_q  <= cfg_data_i;
        gpg_pkg::REG_END:    end_q    <= cfg_data_i;
        gpg_pkg::REG_WIDTH:  width_q  <= cfg_data_i[gpg_pkg::DimW-1:0];
        gpg_pkg::REG_HEIGHT: height_q <= cfg_data_i[gpg_pkg::DimW-1:0];
        gpg_pkg::REG_DIR:    dir_q    <= gpg_pkg::dir_e'(cfg_data_i[1:0]);
        gpg_pkg::REG_NCOL:   ncol_q   <= cfg_data_i[gpg_pkg::NcW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // effective sizes
  logic [gpg_pkg::DimW-1:0] w_eff, h_eff;
  logic [gpg_pkg::NcW-1:0]  n_eff, half, half_m1, last;

  always_comb begin
    if (width_q == '0)                             w_eff = gpg_pkg::DimW'(1);
    else if (width_q > gpg_pkg::DimW'(gpg_pkg::MaxDim)) w_eff = gpg_pkg::DimW'(gpg_pkg::MaxDim);
    else                                           w_eff = width_q;
    if (height_q == '0)                            h_eff = gpg_pkg::DimW'(1);
    else if (height_q > gpg_pkg::DimW'(gpg_pkg::MaxDim)) h_eff = gpg_pkg::DimW'(gpg_pkg::MaxDim);
    else                                           h_eff = height_q;
    if (ncol_q < gpg_pkg::NcW'(2))                 n_eff = gpg_pkg::NcW'(2);
    else if (ncol_q > gpg_pkg::NcW'(gpg_pkg::MaxColors)) n_eff = gpg_pkg::NcW'(gpg_pkg::MaxColors);
    else                                           n_eff = ncol_q;
    half    = n_eff >> 1;
    half_m1 = half - gpg_pkg::NcW'(1);
    last    = n_eff - gpg_pkg::NcW'(1);
  end

  // stage 0: dividends and divisors for the row and column terms
  logic                      v0_q;
  logic [NW-1:0]             numy_q, numx_q;
  logic [DW-1:0]             deny_q, denx_q;
  logic [gpg_pkg::NcW-1:0]   ay, ax;

  always_comb begin
    ay = (dir_q == gpg_pkg::DIR_VERT) ? n_eff : half;
    ax = (dir_q == gpg_pkg::DIR_HORZ) ? n_eff : half_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start;
  end

  always_ff @(posedge clk_i) begin
    numy_q <= {(NW-1)'(ay) * (NW-1)'(pix_i.pixel_y), 1'b0} + NW'(h_eff);
    numx_q <= {(NW-1)'(ax) * (NW-1)'(pix_i.pixel_x), 1'b0} + NW'(w_eff);
    deny_q <= DW'({h_eff, 1'b0});
    denx_q <= DW'({w_eff, 1'b0});
  end

  logic [NW-1:0] qy, qx;

  gpg_div u_div_y (.clk_i, .num_i(numy_q), .den_i(deny_q), .quo_o(qy));
  gpg_div u_div_x (.clk_i, .num_i(numx_q), .den_i(denx_q), .quo_o(qx));

  logic [LAT-1:0] vi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vi_q <= '0;
    else         vi_q <= {vi_q[LAT-2:0], v0_q};
  end

  // index stage
  logic             vidx_q;
  logic [7:0]       idx_q;
  logic signed [NW+2:0] idx_raw;
  logic [7:0]       idx_d;

  always_comb begin
    case (dir_q)
      gpg_pkg::DIR_VERT: idx_raw = (NW+3)'(qy);
      gpg_pkg::DIR_HORZ: idx_raw = (NW+3)'(qx);
      gpg_pkg::DIR_DIAG: idx_raw = (NW+3)'(qy) + (NW+3)'(qx);
      default:           idx_raw = (NW+3)'(qy) + (NW+3)'(half_m1) - (NW+3)'(qx);
    endcase
    if (idx_raw < 0)                          idx_d = '0;
    else if (idx_raw > $signed((NW+3)'(last))) idx_d = last[7:0];
    else                                      idx_d = idx_raw[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vidx_q <= 1'b0;
    else         vidx_q <= vi_q[LAT-1];
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // color stage 0: per-channel dividends
  logic          vc_q;
  logic [7:0]    cidx_q;
  logic [NW-1:0] cnum_q [3];
  logic [2:0]    cneg_q;
  logic [DW-1:0] cden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else         vc_q <= vidx_q;
  end

  always_ff @(posedge clk_i) begin
    logic signed [8:0] diff;
    logic [7:0]        mag;
    for (int k = 0; k < 3; k++) begin
      diff = $signed({1'b0, end_q[8*k +: 8]}) - $signed({1'b0, start_q[8*k +: 8]});
      mag  = diff[8] ? 8'(-diff) : diff[7:0];
      cnum_q[k] <= {(NW-1)'(mag) * (NW-1)'(idx_q), 1'b0} + NW'(last);
      cneg_q[k] <= diff[8];
    end
    cden_q <= DW'({last, 1'b0});
    cidx_q <= idx_q;
  end

  logic [NW-1:0] cq [3];

  for (genvar k = 0; k < 3; k++) begin : g_ch
    gpg_div u_div_c (.clk_i, .num_i(cnum_q[k]), .den_i(cden_q), .quo_o(cq[k]));
  end

  logic [LAT-1:0] vc_line_q;
  logic [7:0]     idx_line_q [LAT];
  logic [2:0]     neg_line_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_line_q <= '0;
    else         vc_line_q <= {vc_line_q[LAT-2:0], vc_q};
  end

  always_ff @(posedge clk_i) begin
    idx_line_q[0] <= cidx_q;
    neg_line_q[0] <= cneg_q;
    for (int s = 1; s < LAT; s++) begin
      idx_line_q[s] <= idx_line_q[s-1];
      neg_line_q[s] <= neg_line_q[s-1];
    end
  end

  // output register
  logic          done_q;
  gpg_pkg::res_t res_q;
  logic [23:0]   rgb_d;

  always_comb begin
    logic [7:0] qk;
    for (int k = 0; k < 3; k++) begin
      qk = cq[k][7:0];
      rgb_d[23-8*k -: 8] = start_q[8*k +: 8] + (neg_line_q[LAT-1][k] ? 8'(-qk) : qk);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vc_line_q[LAT-1];
  end

  always_ff @(posedge clk_i) begin
    res_q.pixel_rgb     <= rgb_d;
    res_q.palette_index <= idx_line_q[LAT-1];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire
